FILE: rtl/tarb_pkg.sv
// Shared types and constants for the timestamped audio ring buffer.
// Depends on nothing; tarb_seq and the top level import it.
`timescale 1ns / 1ps
`default_nettype none

package tarb_pkg;

  // Fixed field widths of the item and result words and of the capacity register.
  localparam int unsigned TIME_W  = 63;
  localparam int unsigned FRAME_W = 64;
  localparam int unsigned KIND_W  = 2;
  localparam int unsigned CAPLG_W = 4;

  // Item kinds.
  localparam logic [KIND_W-1:0] KIND_WRITE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_READ  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;
  localparam logic [KIND_W-1:0] KIND_NONE  = 2'd3;

  // Capacity register value after reset.
  localparam logic [CAPLG_W-1:0] CAPLG_RESET = 4'd12;

  // Last representable sample time; a write there is dropped.
  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

endpackage

`default_nettype wire

FILE: rtl/tarb_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

module tarb_ram #(
  parameter int unsigned WIDTH      = 64,
  parameter int unsigned DEPTH_LOG2 = 12
) (
  input  wire logic                  clk_i,
  input  wire logic                  we_i,
  input  wire logic [DEPTH_LOG2-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]      wdata_i,
  input  wire logic                  re_i,
  input  wire logic [DEPTH_LOG2-1:0] raddr_i,
  output logic      [WIDTH-1:0]      rdata_o
);

  logic [WIDTH-1:0] mem_q [2**DEPTH_LOG2];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port with registered data.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/tarb_seq.sv
// Item sequencer: window bounds, write placement, gap zero-fill and result words.
// Depends on tarb_pkg; drives the frame store ports of tarb_ram.
`timescale 1ns / 1ps
`default_nettype none

module tarb_seq import tarb_pkg::*; #(
  parameter int unsigned AW  = 12,
  parameter int unsigned SW  = 64,
  parameter int unsigned LGW = 4
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // Capacity in use and its slot mask.
  input  wire logic [LGW-1:0]      cap_lg_i,
  input  wire logic [AW-1:0]       slot_mask_i,
  input  wire logic                cfg_we_i,
  // Item word.
  input  wire logic                start,
  output logic                     busy,
  input  wire logic [KIND_W-1:0]   kind_i,
  input  wire logic [TIME_W-1:0]   sample_time_i,
  input  wire logic [FRAME_W-1:0]  frame_in_i,
  input  wire logic                last_in_burst_i,
  // Result word.
  output logic                     done_o,
  output logic      [FRAME_W-1:0]  frame_out_o,
  output logic                     in_window_o,
  output logic      [TIME_W-1:0]   window_start_o,
  output logic      [TIME_W-1:0]   window_end_o,
  output logic                     last_frame_o,
  // Frame store.
  output logic                     ram_we_o,
  output logic      [AW-1:0]       ram_waddr_o,
  output logic      [SW-1:0]       ram_wdata_o,
  output logic                     ram_re_o,
  output logic      [AW-1:0]       ram_raddr_o,
  input  wire logic [SW-1:0]       ram_rdata_i
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EVAL  = 3'd1;
  localparam logic [2:0] S_PLACE = 3'd2;
  localparam logic [2:0] S_GAP   = 3'd3;
  localparam logic [2:0] S_FILL  = 3'd4;
  localparam logic [2:0] S_STORE = 3'd5;

  logic [2:0]         state_q, state_d;
  logic [TIME_W-1:0]  start_q, start_d;
  logic [TIME_W-1:0]  end_q, end_d;
  logic               done_q, done_d;
  logic               hit_q, hit_d;
  logic [FRAME_W-1:0] fout_q, fout_d;
  logic               lastout_q, lastout_d;

  logic [KIND_W-1:0]  kind_q;
  logic [TIME_W-1:0]  t_q;
  logic [SW-1:0]      frame_q;
  logic               last_q;
  logic               back_q, back_d;
  logic               over_q, over_d;
  logic [AW:0]        cnt_q, cnt_d;
  logic [AW-1:0]      addr_q, addr_d;

  logic               accept;
  logic [TIME_W-1:0]  cap_frames;
  logic [TIME_W:0]    start_plus_cap;
  logic [TIME_W-1:0]  new_start;
  logic [TIME_W-1:0]  gap;

  assign accept = start && (state_q == S_IDLE);
  assign busy   = (state_q != S_IDLE);

  // Window arithmetic shared by the write steps.
  assign cap_frames     = TIME_W'(1) << cap_lg_i;
  assign start_plus_cap = {1'b0, start_q} + {1'b0, cap_frames};
  assign new_start      = t_q + TIME_W'(1) - cap_frames;
  assign gap            = t_q - end_q;

  // Reads are issued on the accept edge so the data is ready in the evaluation step.
  assign ram_re_o    = accept;
  assign ram_raddr_o = sample_time_i[AW-1:0] & slot_mask_i;

  // Next-state logic.
  always_comb begin
    state_d     = state_q;
    start_d     = start_q;
    end_d       = end_q;
    done_d      = 1'b0;
    hit_d       = hit_q;
    fout_d      = fout_q;
    lastout_d   = lastout_q;
    back_d      = back_q;
    over_d      = over_q;
    cnt_d       = cnt_q;
    addr_d      = addr_q;
    ram_we_o    = 1'b0;
    ram_waddr_o = addr_q & slot_mask_i;
    ram_wdata_o = '0;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_EVAL;
        end
        if (cfg_we_i) begin
          start_d = '0;
          end_d   = '0;
        end
      end

      S_EVAL: begin
        hit_d     = 1'b0;
        fout_d    = '0;
        lastout_d = last_q;
        unique case (kind_q)
          KIND_WRITE: begin
            if (t_q == TIME_MAX) begin
              done_d  = 1'b1;
              state_d = S_IDLE;
            end else begin
              back_d  = (t_q < end_q);
              over_d  = ({1'b0, t_q} >= start_plus_cap);
              state_d = S_PLACE;
            end
          end
          KIND_READ: begin
            if ((t_q >= start_q) && (t_q < end_q)) begin
              hit_d  = 1'b1;
              fout_d = FRAME_W'(ram_rdata_i);
            end
            done_d  = 1'b1;
            state_d = S_IDLE;
          end
          KIND_CLEAR: begin
            start_d = '0;
            end_d   = '0;
            done_d  = 1'b1;
            state_d = S_IDLE;
          end
          KIND_NONE: begin
            done_d  = 1'b1;
            state_d = S_IDLE;
          end
        endcase
      end

      // A backward write restarts the window; an overlong span pulls the start forward.
      S_PLACE: begin
        if (back_q) begin
          start_d = t_q;
          end_d   = t_q;
        end else if (over_q) begin
          start_d = new_start;
          if (end_q < new_start) begin
            end_d = new_start;
          end
        end
        state_d = S_GAP;
      end

      // Count of skipped slots to zero, at most one full ring.
      S_GAP: begin
        cnt_d  = (gap >= cap_frames) ? cap_frames[AW:0] : gap[AW:0];
        addr_d = t_q[AW-1:0] - AW'(1);
        if (gap == '0) begin
          state_d = S_STORE;
        end else begin
          state_d = S_FILL;
        end
      end

      // Zero one skipped slot a cycle, walking down from the slot before the write.
      S_FILL: begin
        ram_we_o    = 1'b1;
        ram_waddr_o = addr_q & slot_mask_i;
        ram_wdata_o = '0;
        addr_d      = addr_q - AW'(1);
        cnt_d       = cnt_q - (AW+1)'(1);
        if (cnt_q == (AW+1)'(1)) begin
          state_d = S_STORE;
        end
      end

      // The frame goes in last so it wins over a full-ring zero pass.
      S_STORE: begin
        ram_we_o    = 1'b1;
        ram_waddr_o = t_q[AW-1:0] & slot_mask_i;
        ram_wdata_o = frame_q;
        end_d       = t_q + TIME_W'(1);
        done_d      = 1'b1;
        state_d     = S_IDLE;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state and window bounds.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      start_q <= '0;
      end_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      start_q <= start_d;
      end_q   <= end_d;
      done_q  <= done_d;
    end
  end

  // Item word and working payload.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q  <= kind_i;
      t_q     <= sample_time_i;
      frame_q <= frame_in_i[SW-1:0];
      last_q  <= last_in_burst_i;
    end
    back_q    <= back_d;
    over_q    <= over_d;
    cnt_q     <= cnt_d;
    addr_q    <= addr_d;
    hit_q     <= hit_d;
    fout_q    <= fout_d;
    lastout_q <= lastout_d;
  end

  assign done_o         = done_q;
  assign frame_out_o    = fout_q;
  assign in_window_o    = hit_q;
  assign window_start_o = start_q;
  assign window_end_o   = end_q;
  assign last_frame_o   = lastout_q;

endmodule

`default_nettype wire

FILE: rtl/timestamped_audio_ring_buffer.sv
// A read, clear, unused kind or a dropped write at the last time strobes its result from the
// evaluation step; any other write steps through placement, gap count, zero-fill of each
// skipped frame (at most one full ring) and the store, through one write port.
// Busy is high while an item is in progress; no new item is taken until it is done.
// Reset clears the window to empty and sets capacity_log2 to 12; the store needs no clearing.
// Results are strobed by done_o for one cycle and the receiver cannot stall.
`timescale 1ns / 1ps
`default_nettype none

module timestamped_audio_ring_buffer import tarb_pkg::*; #(
  parameter int unsigned MAX_DEPTH_LOG2 = 12,
  parameter int unsigned CHANNELS       = 2,
  parameter int unsigned SAMPLE_BITS    = 32
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [CAPLG_W-1:0]  cfg_wdata_i,
  input  wire logic                start,
  output logic                     busy,
  input  wire logic [KIND_W-1:0]   kind_i,
  input  wire logic [TIME_W-1:0]   sample_time_i,
  input  wire logic [FRAME_W-1:0]  frame_in_i,
  input  wire logic                last_in_burst_i,
  output logic                     done_o,
  output logic      [FRAME_W-1:0]  frame_out_o,
  output logic                     in_window_o,
  output logic      [TIME_W-1:0]   window_start_o,
  output logic      [TIME_W-1:0]   window_end_o,
  output logic                     last_frame_o
);

  localparam int unsigned AW         = MAX_DEPTH_LOG2;
  localparam int unsigned LGW        = $clog2(MAX_DEPTH_LOG2 + 1);
  localparam int unsigned FRAME_BITS = CHANNELS * SAMPLE_BITS;
  localparam int unsigned SW         = (FRAME_BITS >= FRAME_W) ? FRAME_W : FRAME_BITS;

  logic [CAPLG_W-1:0] cap_q;
  logic [LGW-1:0]     cap_lg;
  logic [AW-1:0]      slot_mask;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [SW-1:0] ram_wdata;
  logic          ram_re;
  logic [AW-1:0] ram_raddr;
  logic [SW-1:0] ram_rdata;

  // Capacity register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CAPLG_RESET;
    end else if (cfg_we_i) begin
      cap_q <= cfg_wdata_i;
    end
  end

  // Clamp the capacity to the range the store supports.
  always_comb begin
    priority if (cap_q == '0) begin
      cap_lg = LGW'(1);
    end else if (32'(cap_q) > MAX_DEPTH_LOG2) begin
      cap_lg = LGW'(MAX_DEPTH_LOG2);
    end else begin
      cap_lg = LGW'(cap_q);
    end
  end

  // Slot mask keeps the low cap_lg bits of a time.
  always_comb begin
    for (int i = 0; i < AW; i++) begin
      slot_mask[i] = (i < 32'(cap_lg));
    end
  end

  tarb_seq #(
    .AW  (AW),
    .SW  (SW),
    .LGW (LGW)
  ) u_seq (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cap_lg_i        (cap_lg),
    .slot_mask_i     (slot_mask),
    .cfg_we_i        (cfg_we_i),
    .start           (start),
    .busy            (busy),
    .kind_i          (kind_i),
    .sample_time_i   (sample_time_i),
    .frame_in_i      (frame_in_i),
    .last_in_burst_i (last_in_burst_i),
    .done_o          (done_o),
    .frame_out_o     (frame_out_o),
    .in_window_o     (in_window_o),
    .window_start_o  (window_start_o),
    .window_end_o    (window_end_o),
    .last_frame_o    (last_frame_o),
    .ram_we_o        (ram_we),
    .ram_waddr_o     (ram_waddr),
    .ram_wdata_o     (ram_wdata),
    .ram_re_o        (ram_re),
    .ram_raddr_o     (ram_raddr),
    .ram_rdata_i     (ram_rdata)
  );

  tarb_ram #(
    .WIDTH      (SW),
    .DEPTH_LOG2 (AW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

`ifndef NO_ASSERTIONS
  // The window is never inverted when a result is shown.
  a_window_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (window_start_o <= window_end_o))
    else $error("window start past window end");

  // The window never spans more than the capacity in use.
  a_window_span: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ((window_end_o - window_start_o) <= (TIME_W'(1) << cap_lg)))
    else $error("window wider than capacity");

  // An accepted word keeps the block busy on the next cycle.
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted word did not raise busy");

  // Two results never come back to back.
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe held for two cycles");

  // A miss or a non-read carries zero data.
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !in_window_o) |-> (frame_out_o == '0))
    else $error("nonzero data without a window hit");
`endif

endmodule

`default_nettype wire
